// ----- hw/rtl/tmsw_pkg.sv -----
package tmsw_pkg;

  // Field widths
  localparam int unsigned SAMPLE_W    = 10;
  localparam int unsigned TURB_W      = 16;
  localparam int unsigned INTERVAL_W  = 8;
  localparam int unsigned SIZE_W      = 6;
  localparam int unsigned TICK_W      = 9;
  localparam int unsigned CFG_DATA_W  = 8;
  localparam int unsigned CFG_ADDR_W  = 1;
  localparam int unsigned IN_TDATA_W  = 16;
  localparam int unsigned OUT_TDATA_W = 32;

  // Window depth default
  localparam int unsigned MAX_WINDOW_DEF = 32;

  // Register reset values
  localparam logic [INTERVAL_W-1:0] INTERVAL_RST = 8'd100;
  localparam logic [SIZE_W-1:0]     SIZE_RST     = 6'd10;

  // Register indexes
  localparam logic [CFG_ADDR_W-1:0] CFG_IDX_INTERVAL = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] CFG_IDX_SIZE     = 1'b1;

  // Windows smaller than this use the plain mean
  localparam int unsigned TRIM_MIN_SIZE = 5;

  // Turbidity: q16 = (avg*33120 - 19136512 + 500 + 20000000) / 1000 - 20000,
  // which equals (avg*4140 + 107998) / 125 - 20000. The divide by 125 is a
  // multiply by ceil(2^26/125) and a shift by 26, exact for dividends below 2^26/11.
  localparam int unsigned PROD_W      = 23;
  localparam int unsigned TURB_SCALE  = 4140;
  localparam int unsigned TURB_OFFSET = 107998;
  localparam int unsigned RCP_W       = 20;
  localparam int unsigned TURB_RCP    = 536871;
  localparam int unsigned TURB_RCP_SH = 26;
  localparam int unsigned RPROD_W     = PROD_W + RCP_W;
  localparam int unsigned TURB_BIAS   = 20000;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DIV,
    ST_MUL,
    ST_OUT
  } tmsw_state_t;

endpackage

// ----- hw/rtl/trimmed_mean_sensor_window_top.sv -----
// Trimmed-mean sensor window.
// Input channel (in_*): one word per timer tick, carrying the current 10-bit
// converter sample. Once the tick count since the last sample exceeds
// sample_interval, the sample enters a circular window of window_size
// entries and the block averages the window: plain floor mean below five
// entries, else the sum less one minimum and one maximum over size minus two.
// Ticks that take no sample produce no result word.
// Result channel (out_*): one word per sample: the average in codes and a
// signed Q16 turbidity value.
// Configuration (cfg_*): write enable, register index, data; write only
// while idle. Index 0 is sample_interval, index 1 is window_size.
// A sampling tick runs n reads of the window memory for n entries, two steps
// to close the scan, 23 steps of the shared divider for the mean, one to
// scale and one to load the output word; in_tready is low throughout, until
// the block is back in idle; one item is in work at a time.
// A finished word waits in the output register; a stalled receiver holds
// the block in its last step until that register is free.
// Reset (rst_n, synchronous, active low) clears the window through per-entry
// valid bits at once, zeroes the tick counter and write index, and loads
// the register defaults (interval 100, size 10). No clearing pass is needed.
module trimmed_mean_sensor_window_top #(
  parameter int unsigned MAX_WINDOW = tmsw_pkg::MAX_WINDOW_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // [9:0] adc_sample, [15:10] zero
  input  logic [tmsw_pkg::IN_TDATA_W-1:0]    in_tdata,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // [9:0] average_code, [25:10] turbidity_q16, [31:26] zero
  output logic [tmsw_pkg::OUT_TDATA_W-1:0]   out_tdata,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  input  logic                               cfg_wen,
  input  logic [tmsw_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  logic [tmsw_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
  import tmsw_pkg::*;

  // Derived widths
  localparam int unsigned IW  = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1; // entry index
  localparam int unsigned NW  = $clog2(MAX_WINDOW + 1);                    // entry count
  localparam int unsigned SW  = SAMPLE_W + NW;                             // window sum
  localparam int unsigned DW  = (SW > PROD_W) ? SW : PROD_W;               // dividend
  localparam int unsigned VW  = (NW > 10) ? NW : 10;                       // divisor
  localparam int unsigned STW = $clog2(DW);                                // divide step

  // Configuration registers
  logic [INTERVAL_W-1:0] interval_r;
  logic [SIZE_W-1:0]     size_r;

  // Sequencer state
  tmsw_state_t state_r, state_nxt;
  logic [TICK_W-1:0]   tick_r, tick_nxt;
  logic [IW-1:0]       wi_r, wi_nxt;
  logic [NW-1:0]       n_r, n_nxt;
  logic [NW-1:0]       cnt_r, cnt_nxt;
  logic                pend_r, pend_nxt;
  logic [SW-1:0]       sum_r, sum_nxt;
  logic [SAMPLE_W-1:0] lo_r, lo_nxt;
  logic [SAMPLE_W-1:0] hi_r, hi_nxt;
  logic [SAMPLE_W-1:0] avg_r, avg_nxt;

  // Shared divider
  logic [DW-1:0]  quo_r, quo_nxt;
  logic [VW-1:0]  rem_r, rem_nxt;
  logic [VW-1:0]  dvs_r, dvs_nxt;
  logic [STW-1:0] step_r, step_nxt;

  // Output register
  logic [OUT_TDATA_W-1:0] out_data_r, out_data_nxt;
  logic                   out_valid_r, out_valid_nxt;

  // Window memory
  logic [SAMPLE_W-1:0] win_mem [MAX_WINDOW];
  logic [MAX_WINDOW-1:0] vld_r;
  logic                mem_we;
  logic [IW-1:0]       mem_waddr;
  logic                mem_re;
  logic [IW-1:0]       mem_raddr;
  logic [SAMPLE_W-1:0] rd_data_r;
  logic                rd_vld_r;

  // Combinational helpers
  logic [TICK_W-1:0]   tick_inc;
  logic                take_sample;
  logic [NW-1:0]       n_eff;
  logic [NW-1:0]       widx_full;
  logic [IW-1:0]       widx;
  logic [NW-1:0]       wnext;
  logic [SAMPLE_W-1:0] scan_val;
  logic [VW:0]         trial;
  logic [VW:0]         trial_diff;
  logic                trial_ge;
  logic [PROD_W-1:0]   prod;
  logic [RPROD_W-1:0]  rcp_prod;
  logic [TURB_W-1:0]   turb;

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tdata  = out_data_r;
  assign out_tvalid = out_valid_r;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      interval_r <= INTERVAL_RST;
      size_r     <= SIZE_RST;
    end else if (cfg_wen) begin
      unique case (cfg_addr)
        CFG_IDX_INTERVAL: interval_r <= cfg_wdata[INTERVAL_W-1:0];
        CFG_IDX_SIZE:     size_r     <= cfg_wdata[SIZE_W-1:0];
        default:          ;
      endcase
    end
  end

  // Tick count, saturating at its maximum; sample once it passes the interval
  always_comb begin
    tick_inc    = (tick_r == '1) ? tick_r : tick_r + TICK_W'(1);
    take_sample = (tick_inc > {1'b0, interval_r});
  end

  // Effective window size: zero acts as one, clamp to the memory depth
  always_comb begin
    if (size_r == '0) begin
      n_eff = NW'(1);
    end else if (32'(size_r) > MAX_WINDOW) begin
      n_eff = NW'(MAX_WINDOW);
    end else begin
      n_eff = NW'(size_r);
    end
  end

  // Write slot: wrap to zero if the size has shrunk under the index
  always_comb begin
    widx_full = (NW'(wi_r) >= n_eff) ? '0 : NW'(wi_r);
    widx      = widx_full[IW-1:0];
    wnext     = widx_full + NW'(1);
  end

  // Unwritten entries count as zero
  assign scan_val = rd_vld_r ? rd_data_r : '0;

  // One restoring step of the divider
  always_comb begin
    trial      = {rem_r, quo_r[DW-1]};
    trial_ge   = (trial >= {1'b0, dvs_r});
    trial_diff = trial - {1'b0, dvs_r};
  end

  // Turbidity: scale the average, then divide by 125 through the reciprocal
  assign prod     = PROD_W'(avg_r) * PROD_W'(TURB_SCALE) + PROD_W'(TURB_OFFSET);
  assign rcp_prod = RPROD_W'(quo_r[PROD_W-1:0]) * RPROD_W'(TURB_RCP);
  assign turb     = rcp_prod[TURB_RCP_SH +: TURB_W] - TURB_W'(TURB_BIAS);

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    tick_nxt      = tick_r;
    wi_nxt        = wi_r;
    n_nxt         = n_r;
    cnt_nxt       = cnt_r;
    pend_nxt      = pend_r;
    sum_nxt       = sum_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    avg_nxt       = avg_r;
    quo_nxt       = quo_r;
    rem_nxt       = rem_r;
    dvs_nxt       = dvs_r;
    step_nxt      = step_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_tready;
    mem_we        = 1'b0;
    mem_waddr     = widx;
    mem_re        = 1'b0;
    mem_raddr     = cnt_r[IW-1:0];

    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          if (take_sample) begin
            // store the sample, advance the slot, start the scan
            tick_nxt  = '0;
            mem_we    = 1'b1;
            wi_nxt    = (wnext >= n_eff) ? '0 : wnext[IW-1:0];
            n_nxt     = n_eff;
            cnt_nxt   = '0;
            pend_nxt  = 1'b0;
            sum_nxt   = '0;
            lo_nxt    = '1;
            hi_nxt    = '0;
            state_nxt = ST_SCAN;
          end else begin
            tick_nxt = tick_inc;
          end
        end
      end

      ST_SCAN: begin
        if (pend_r) begin
          sum_nxt = sum_r + SW'(scan_val);
          if (scan_val < lo_r) lo_nxt = scan_val;
          if (scan_val > hi_r) hi_nxt = scan_val;
        end
        if (cnt_r != n_r) begin
          mem_re   = 1'b1;
          cnt_nxt  = cnt_r + NW'(1);
          pend_nxt = 1'b1;
        end else begin
          pend_nxt = 1'b0;
          if (!pend_r) begin
            // sum, minimum and maximum are complete: load the divider
            if (32'(n_r) < TRIM_MIN_SIZE) begin
              quo_nxt = DW'(sum_r);
              dvs_nxt = VW'(n_r);
            end else begin
              quo_nxt = DW'(sum_r - SW'(lo_r) - SW'(hi_r));
              dvs_nxt = VW'(n_r) - VW'(2);
            end
            rem_nxt   = '0;
            step_nxt  = '0;
            state_nxt = ST_DIV;
          end
        end
      end

      ST_DIV: begin
        rem_nxt  = trial_ge ? trial_diff[VW-1:0] : trial[VW-1:0];
        quo_nxt  = {quo_r[DW-2:0], trial_ge};
        step_nxt = step_r + STW'(1);
        if (step_r == STW'(DW - 1)) begin
          avg_nxt   = quo_nxt[SAMPLE_W-1:0];
          state_nxt = ST_MUL;
        end
      end

      ST_MUL: begin
        // hold the scaled average in the dividend register for the output step
        quo_nxt   = DW'(prod);
        state_nxt = ST_OUT;
      end

      ST_OUT: begin
        if (!out_valid_r || out_tready) begin
          out_data_nxt  = OUT_TDATA_W'({turb, avg_r});
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      tick_r      <= '0;
      wi_r        <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      tick_r      <= tick_nxt;
      wi_r        <= wi_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    n_r        <= n_nxt;
    cnt_r      <= cnt_nxt;
    sum_r      <= sum_nxt;
    lo_r       <= lo_nxt;
    hi_r       <= hi_nxt;
    avg_r      <= avg_nxt;
    quo_r      <= quo_nxt;
    rem_r      <= rem_nxt;
    dvs_r      <= dvs_nxt;
    step_r     <= step_nxt;
    out_data_r <= out_data_nxt;
  end

  // Per-entry valid bits stand in for clearing the window at reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (mem_we) begin
      vld_r[mem_waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      win_mem[mem_waddr] <= in_tdata[SAMPLE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (mem_re) begin
      rd_data_r <= win_mem[mem_raddr];
      rd_vld_r  <= vld_r[mem_raddr];
    end
  end

endmodule
